FILE: hw/rtl/gea_pkg.sv
// Shared types, codes and constants for the greedy element agglomeration engine.
`default_nettype none

package gea_pkg;

	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int DEF_MAX_ENTRIES = 16384;
	localparam int DEF_MAX_MEMBERS = 128;

	localparam int ACC_W = 24;
	localparam int WEIGHT_W = 16;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	localparam logic [10:0] RST_ELEMENT_COUNT = 11'd1;
	localparam logic [31:0] RST_ELEMENT_BASE = 32'd0;
	localparam logic [15:0] RST_GROW_THRESHOLD = 16'd4;
	localparam logic [15:0] RST_ATTACH_THRESHOLD = 16'd3;
	localparam logic [7:0] RST_MAX_MACRO_SIZE = 8'd100;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_RUN = 2'd1,
		ACT_READ = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK = 2'd0,
		STS_FULL = 2'd1,
		STS_ORDER = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_ELEMENT_COUNT = 3'd0,
		REG_ELEMENT_BASE = 3'd1,
		REG_GROW_THRESHOLD = 3'd2,
		REG_ATTACH_THRESHOLD = 3'd3,
		REG_MAX_MACRO_SIZE = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_CLR,
		ST_ROOT_RD,
		ST_ROOT_CHK,
		ST_SPAN0,
		ST_SPAN1,
		ST_SPAN2,
		ST_SCAN,
		ST_ENT_WAIT,
		ST_EL_WAIT,
		ST_GROW_CHK,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_ATT_RD,
		ST_ATT_CHK,
		ST_ATT_END,
		ST_SGL_RD,
		ST_SGL_CHK
	} state_t;

	typedef struct packed {
		logic [10:0] element_count;
		logic [31:0] element_base;
		logic [15:0] grow_threshold;
		logic [15:0] attach_threshold;
		logic [7:0] max_macro_size;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gea_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module gea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gea_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module gea_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output gea_pkg::cfg_t cfg
);
	import gea_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.element_count <= RST_ELEMENT_COUNT;
			cfg_q.element_base <= RST_ELEMENT_BASE;
			cfg_q.grow_threshold <= RST_GROW_THRESHOLD;
			cfg_q.attach_threshold <= RST_ATTACH_THRESHOLD;
			cfg_q.max_macro_size <= RST_MAX_MACRO_SIZE;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_ELEMENT_COUNT: cfg_q.element_count <= pwdata[10:0];
				REG_ELEMENT_BASE: cfg_q.element_base <= pwdata;
				REG_GROW_THRESHOLD: cfg_q.grow_threshold <= pwdata[15:0];
				REG_ATTACH_THRESHOLD: cfg_q.attach_threshold <= pwdata[15:0];
				REG_MAX_MACRO_SIZE: cfg_q.max_macro_size <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[4:2]))
			REG_ELEMENT_COUNT: prdata = {21'd0, cfg_q.element_count};
			REG_ELEMENT_BASE: prdata = cfg_q.element_base;
			REG_GROW_THRESHOLD: prdata = {16'd0, cfg_q.grow_threshold};
			REG_ATTACH_THRESHOLD: prdata = {16'd0, cfg_q.attach_threshold};
			REG_MAX_MACRO_SIZE: prdata = {24'd0, cfg_q.max_macro_size};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gea_core.sv
// Sequencer that loads the graph and runs agglomeration over the graph and element memories.
`default_nettype none

module gea_core #(
	parameter int MAX_ELEMENTS = gea_pkg::DEF_MAX_ELEMENTS,
	parameter int MAX_ENTRIES = gea_pkg::DEF_MAX_ENTRIES,
	parameter int MAX_MEMBERS = gea_pkg::DEF_MAX_MEMBERS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire gea_pkg::cfg_t cfg,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] action,
	input wire logic [9:0] row,
	input wire logic [31:0] column,
	input wire logic [15:0] weight,
	input wire logic [9:0] read_element,
	output logic done,
	output logic [1:0] status,
	output logic [9:0] label,
	output logic [10:0] macro_count
);
	import gea_pkg::*;

	localparam int EL_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int ENT_W = $clog2(MAX_ENTRIES);
	localparam int ET_W = $clog2(MAX_ENTRIES + 1);
	localparam int MB_W = $clog2(MAX_MEMBERS);
	localparam int MC_W = $clog2(MAX_MEMBERS + 1);
	localparam int EW = 2 * EL_W + ACC_W + 2;
	localparam int EN_W = EL_W + WEIGHT_W;
	localparam logic [EW-1:0] WORD_INATT = {2'b01, {(EW - 2){1'b0}}};

	state_t state_q, state_d;
	logic phase_att_q;
	logic first_q;
	logic [CNT_W-1:0] i_q;
	logic [MC_W-1:0] cnt_q;
	logic [MC_W-1:0] fin_k_q;
	logic [ACC_W-1:0] cur_w_q;
	logic [ACC_W-1:0] best_q;
	logic [EL_W-1:0] cur_i_q;
	logic [EL_W-1:0] pick_q;
	logic found_q;
	logic [EL_W-1:0] span_row_q;
	logic [ET_W-1:0] b_q;
	logic [ET_W-1:0] e_q;
	logic [ET_W-1:0] k_q;
	logic [EL_W-1:0] col_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [ET_W-1:0] total_q;
	logic [EL_W-1:0] last_row_q;
	logic [CNT_W-1:0] macros_q;
	logic [CNT_W-1:0] labeled_q;
	logic [9:0] re_q;
	logic done_q;
	status_t status_q;
	logic [9:0] label_q;

	logic el_we;
	logic [EL_W-1:0] el_waddr, el_raddr;
	logic [EW-1:0] el_wdata, el_rdata;
	logic rs_we;
	logic [CNT_W-1:0] rs_waddr, rs_raddr;
	logic [ET_W-1:0] rs_wdata, rs_rdata;
	logic en_we;
	logic [ENT_W-1:0] en_waddr, en_raddr;
	logic [EN_W-1:0] en_wdata, en_rdata;
	logic mb_we;
	logic [MB_W-1:0] mb_waddr, mb_raddr;
	logic [EL_W-1:0] mb_wdata, mb_rdata;

	logic [CNT_W-1:0] n;
	int lim;
	logic accept;
	logic el_valid, el_inatt;
	logic [EL_W-1:0] el_label, el_tag;
	logic [ACC_W-1:0] el_acc, acc_eff, s_val;
	logic [ACC_W:0] sum;
	logic elig, att_hit, grow_ok, i_end, read_ok;
	logic [31:0] local_col;
	status_t ld_status;
	logic ld_store;

	gea_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_el_ram (
		.clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
		.raddr(el_raddr), .rdata(el_rdata)
	);

	gea_ram #(.WIDTH(ET_W), .DEPTH(MAX_ELEMENTS + 1)) u_rs_ram (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.raddr(rs_raddr), .rdata(rs_rdata)
	);

	gea_ram #(.WIDTH(EN_W), .DEPTH(MAX_ENTRIES)) u_en_ram (
		.clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
		.raddr(en_raddr), .rdata(en_rdata)
	);

	gea_ram #(.WIDTH(EL_W), .DEPTH(MAX_MEMBERS)) u_mb_ram (
		.clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
		.raddr(mb_raddr), .rdata(mb_rdata)
	);

	assign n = (32'(cfg.element_count) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
		: CNT_W'(cfg.element_count);
	assign lim = (int'(cfg.max_macro_size) > MAX_MEMBERS) ? MAX_MEMBERS
		: int'(cfg.max_macro_size);
	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	assign el_valid = el_rdata[EW-1];
	assign el_inatt = el_rdata[EW-2];
	assign el_label = el_rdata[EW-3 -: EL_W];
	assign el_acc = el_rdata[EL_W +: ACC_W];
	assign el_tag = el_rdata[0 +: EL_W];

	assign acc_eff = (el_tag == EL_W'(i_q)) ? el_acc : '0;
	assign sum = {1'b0, acc_eff} + {{(ACC_W + 1 - WEIGHT_W){1'b0}}, w_q};
	assign s_val = first_q ? ACC_W'(w_q) : (sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0]);
	assign elig = (CNT_W'(col_q) < n) && !el_valid && !el_inatt;
	assign att_hit = (CNT_W'(col_q) < n) && el_valid && (ACC_W'(w_q) > best_q);
	assign grow_ok = (cur_w_q >= ACC_W'(cfg.grow_threshold)) && (cur_w_q > best_q)
		&& (int'(cnt_q) < lim);
	assign i_end = (i_q >= n);
	assign read_ok = (32'(re_q) < 32'(n)) && (32'(re_q) < 32'(labeled_q));
	assign local_col = column - cfg.element_base;

	always_comb begin
		ld_store = 1'b0;
		ld_status = STS_OK;
		if (32'(row) >= 32'(n)) begin
			ld_status = STS_RANGE;
		end else if (32'(row) < 32'(last_row_q)) begin
			ld_status = STS_ORDER;
		end else if (local_col >= 32'(n)) begin
			ld_status = STS_OK;
		end else if (32'(total_q) >= MAX_ENTRIES) begin
			ld_status = STS_FULL;
		end else begin
			ld_store = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		el_we = 1'b0;
		el_waddr = EL_W'(i_q);
		el_wdata = '0;
		el_raddr = EL_W'(i_q);
		rs_we = 1'b0;
		rs_waddr = i_q;
		rs_wdata = b_q;
		rs_raddr = CNT_W'(span_row_q);
		en_we = 1'b0;
		en_waddr = ENT_W'(total_q);
		en_wdata = {EL_W'(local_col), weight};
		en_raddr = ENT_W'(k_q);
		mb_we = 1'b0;
		mb_waddr = MB_W'(cnt_q);
		mb_wdata = cur_i_q;
		mb_raddr = MB_W'(fin_k_q);
		case (state_q)
			ST_IDLE: begin
				el_raddr = EL_W'(read_element);
				if (accept) begin
					case (action_t'(action))
						ACT_LOAD: begin
							if (ld_store) begin
								en_we = 1'b1;
								if (EL_W'(row) != last_row_q) begin
									state_d = ST_FILL;
								end
							end
						end
						ACT_RUN: state_d = ST_CLR;
						ACT_READ: state_d = ST_READ;
						ACT_CLEAR: state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				rs_we = 1'b1;
				if (i_q == CNT_W'(span_row_q)) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_CLR: begin
				if (i_end) begin
					state_d = ST_ROOT_RD;
				end else begin
					el_we = 1'b1;
				end
			end
			ST_ROOT_RD: state_d = i_end ? ST_ATT_RD : ST_ROOT_CHK;
			ST_ROOT_CHK: begin
				if (el_valid) begin
					state_d = ST_ROOT_RD;
				end else begin
					el_we = 1'b1;
					el_wdata = WORD_INATT;
					mb_we = 1'b1;
					mb_waddr = '0;
					mb_wdata = EL_W'(i_q);
					state_d = ST_SPAN0;
				end
			end
			ST_SPAN0: state_d = (span_row_q > last_row_q) ? ST_SCAN : ST_SPAN1;
			ST_SPAN1: begin
				rs_raddr = CNT_W'(span_row_q) + 1'b1;
				state_d = (span_row_q == last_row_q) ? ST_SCAN : ST_SPAN2;
			end
			ST_SPAN2: state_d = ST_SCAN;
			ST_SCAN: begin
				if (k_q >= e_q) begin
					state_d = phase_att_q ? ST_ATT_END : ST_GROW_CHK;
				end else begin
					state_d = ST_ENT_WAIT;
				end
			end
			ST_ENT_WAIT: begin
				el_raddr = en_rdata[EN_W-1 -: EL_W];
				state_d = ST_EL_WAIT;
			end
			ST_EL_WAIT: begin
				el_waddr = col_q;
				el_wdata = {2'b00, el_label, s_val, EL_W'(i_q)};
				el_we = !phase_att_q && elig;
				state_d = ST_SCAN;
			end
			ST_GROW_CHK: begin
				if (grow_ok) begin
					mb_we = 1'b1;
					el_we = 1'b1;
					el_waddr = cur_i_q;
					el_wdata = WORD_INATT;
					state_d = ST_SPAN0;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_FIN_RD: state_d = ST_FIN_WR;
			ST_FIN_WR: begin
				el_we = 1'b1;
				el_waddr = mb_rdata;
				el_wdata = {cnt_q > MC_W'(1), 1'b0, EL_W'(macros_q), {(ACC_W + EL_W){1'b0}}};
				state_d = (MC_W'(fin_k_q + 1'b1) == cnt_q) ? ST_ROOT_RD : ST_FIN_RD;
			end
			ST_ATT_RD: state_d = i_end ? ST_SGL_RD : ST_ATT_CHK;
			ST_ATT_CHK: state_d = el_valid ? ST_ATT_RD : ST_SPAN0;
			ST_ATT_END: begin
				el_we = found_q;
				el_wdata = {2'b10, pick_q, {(ACC_W + EL_W){1'b0}}};
				state_d = ST_ATT_RD;
			end
			ST_SGL_RD: state_d = i_end ? ST_IDLE : ST_SGL_CHK;
			ST_SGL_CHK: begin
				el_we = !el_valid;
				el_wdata = {2'b10, EL_W'(macros_q), {(ACC_W + EL_W){1'b0}}};
				state_d = ST_SGL_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			last_row_q <= '0;
			macros_q <= '0;
			labeled_q <= '0;
			done_q <= 1'b0;
			status_q <= STS_OK;
			label_q <= '0;
		end else begin
			done_q <= 1'b0;
			label_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= STS_OK;
						case (action_t'(action))
							ACT_LOAD: begin
								if (ld_store) begin
									total_q <= total_q + 1'b1;
									last_row_q <= EL_W'(row);
									if (EL_W'(row) == last_row_q) begin
										done_q <= 1'b1;
									end
								end else begin
									done_q <= 1'b1;
									status_q <= ld_status;
								end
							end
							ACT_RUN: macros_q <= '0;
							ACT_READ: ;
							ACT_CLEAR: begin
								total_q <= '0;
								last_row_q <= '0;
								done_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_FILL: begin
					if (i_q == CNT_W'(span_row_q)) begin
						done_q <= 1'b1;
					end
				end
				ST_READ: begin
					done_q <= 1'b1;
					status_q <= read_ok ? STS_OK : STS_RANGE;
					label_q <= read_ok ? 10'(el_label) : '0;
				end
				ST_FIN_WR: begin
					if (MC_W'(fin_k_q + 1'b1) == cnt_q && cnt_q > MC_W'(1)) begin
						macros_q <= macros_q + 1'b1;
					end
				end
				ST_SGL_RD: begin
					if (i_end) begin
						labeled_q <= n;
						done_q <= 1'b1;
						status_q <= STS_OK;
					end
				end
				ST_SGL_CHK: begin
					if (!el_valid) begin
						macros_q <= macros_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				b_q <= total_q;
				i_q <= CNT_W'(last_row_q) + 1'b1;
				span_row_q <= EL_W'(row);
				re_q <= read_element;
				if (action_t'(action) == ACT_RUN) begin
					i_q <= '0;
				end
			end
			ST_FILL: i_q <= i_q + 1'b1;
			ST_CLR: i_q <= i_end ? '0 : i_q + 1'b1;
			ST_ROOT_RD: begin
				if (i_end) begin
					i_q <= '0;
				end
			end
			ST_ROOT_CHK: begin
				if (el_valid) begin
					i_q <= i_q + 1'b1;
				end else begin
					cnt_q <= MC_W'(1);
					cur_w_q <= '0;
					cur_i_q <= EL_W'(i_q);
					best_q <= '0;
					first_q <= 1'b1;
					phase_att_q <= 1'b0;
					span_row_q <= EL_W'(i_q);
				end
			end
			ST_SPAN0: begin
				if (span_row_q > last_row_q) begin
					k_q <= '0;
					e_q <= '0;
				end
			end
			ST_SPAN1: begin
				k_q <= (span_row_q == '0) ? '0 : rs_rdata;
				if (span_row_q == last_row_q) begin
					e_q <= total_q;
				end
			end
			ST_SPAN2: e_q <= rs_rdata;
			ST_ENT_WAIT: begin
				col_q <= en_rdata[EN_W-1 -: EL_W];
				w_q <= en_rdata[WEIGHT_W-1:0];
			end
			ST_EL_WAIT: begin
				k_q <= k_q + 1'b1;
				if (!phase_att_q && elig && s_val > cur_w_q) begin
					cur_w_q <= s_val;
					cur_i_q <= col_q;
				end
				if (phase_att_q && att_hit) begin
					best_q <= ACC_W'(w_q);
					pick_q <= el_label;
					found_q <= 1'b1;
				end
			end
			ST_GROW_CHK: begin
				if (grow_ok) begin
					best_q <= cur_w_q;
					cnt_q <= cnt_q + 1'b1;
					span_row_q <= cur_i_q;
					first_q <= 1'b0;
				end else begin
					fin_k_q <= '0;
				end
			end
			ST_FIN_WR: begin
				fin_k_q <= fin_k_q + 1'b1;
				if (MC_W'(fin_k_q + 1'b1) == cnt_q) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_ATT_RD: begin
				if (i_end) begin
					i_q <= '0;
				end
			end
			ST_ATT_CHK: begin
				if (el_valid) begin
					i_q <= i_q + 1'b1;
				end else begin
					best_q <= ACC_W'(cfg.attach_threshold);
					found_q <= 1'b0;
					phase_att_q <= 1'b1;
					span_row_q <= EL_W'(i_q);
				end
			end
			ST_ATT_END: i_q <= i_q + 1'b1;
			ST_SGL_CHK: i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

	assign done = done_q;
	assign status = status_q;
	assign label = label_q;
	assign macro_count = 11'(macros_q);

endmodule

`default_nettype wire

FILE: hw/rtl/greedy_element_agglomeration.sv
// Top level of the greedy element agglomeration engine.
// Every command gives exactly one result beat, shown for one cycle with done high, and the
// receiver cannot stall it. A load on the current row, or one that is refused, has its result
// registered in the cycle after it is taken; a load that starts a new row stays busy while it
// writes each row offset into the row start memory and gives its result after the last one.
// A read passes through the read state before its result is registered; a clear registers
// its result straight from idle. A run clears the element table, grows a macroelement from
// each free root by scanning the row spans of its members, labels them if it grew, then
// attaches each leftover element by its best weight and gives any still left its own label.
`default_nettype none

module greedy_element_agglomeration #(
	parameter int MAX_ELEMENTS = gea_pkg::DEF_MAX_ELEMENTS,
	parameter int MAX_ENTRIES = gea_pkg::DEF_MAX_ENTRIES,
	parameter int MAX_MEMBERS = gea_pkg::DEF_MAX_MEMBERS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] action,
	input wire logic [9:0] row,
	input wire logic [31:0] column,
	input wire logic [15:0] weight,
	input wire logic [9:0] read_element,
	output logic done,
	output logic [1:0] status,
	output logic [9:0] label,
	output logic [10:0] macro_count
);
	import gea_pkg::*;

	cfg_t cfg;

	gea_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	gea_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_ENTRIES(MAX_ENTRIES),
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .start(start), .busy(busy),
		.action(action), .row(row), .column(column), .weight(weight),
		.read_element(read_element), .done(done), .status(status), .label(label),
		.macro_count(macro_count)
	);

endmodule

`default_nettype wire

FILE: dv/gea_checker.sv
// Checker for the greedy element agglomeration engine: predicts every result beat and compares it.
`timescale 1ns / 100ps

module gea_checker
	import gea_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	input logic start,
	input logic busy,
	input logic [1:0] action,
	input logic [9:0] row,
	input logic [31:0] column,
	input logic [15:0] weight,
	input logic [9:0] read_element,
	input logic done,
	input logic [1:0] status,
	input logic [9:0] label,
	input logic [10:0] macro_count,
	output int errors,
	output int pending
);

	localparam int N_MAX = 1024;
	localparam int E_MAX = 16384;
	localparam int M_MAX = 128;
	localparam int SAT = 24'hFFFFFF;

	typedef struct {
		status_t st;
		logic [9:0] lbl;
		logic [10:0] cnt;
	} beat_t;

	beat_t owed[$];

	cfg_t cfg;
	int row_base[N_MAX+1];
	int ent_col[E_MAX];
	int ent_wt[E_MAX];
	int ent_total;
	int top_row;
	int mlabel[N_MAX];
	bit labeled[N_MAX];
	int acc[N_MAX];
	bit joined[N_MAX];
	int members[M_MAX];
	int formed;

	initial errors = 0;

	function automatic int live_count();
		return cfg.element_count > N_MAX ? N_MAX : int'(cfg.element_count);
	endfunction

	function automatic void row_range(input int r, output int b, output int e);
		b = 0;
		e = 0;
		if (r < top_row) begin
			b = row_base[r];
			e = row_base[r+1];
		end else if (r == top_row) begin
			b = row_base[r];
			e = ent_total;
		end
	endfunction

	function automatic bit can_join(input int c, input int n);
		return c < n && !labeled[c] && !joined[c];
	endfunction

	function automatic void clear_graph();
		ent_total = 0;
		top_row = 0;
		row_base[0] = 0;
	endfunction

	function automatic void model_reset();
		cfg.element_count = RST_ELEMENT_COUNT;
		cfg.element_base = RST_ELEMENT_BASE;
		cfg.grow_threshold = RST_GROW_THRESHOLD;
		cfg.attach_threshold = RST_ATTACH_THRESHOLD;
		cfg.max_macro_size = RST_MAX_MACRO_SIZE;
		clear_graph();
		for (int i = 0; i < N_MAX; i++) begin
			mlabel[i] = 0;
			labeled[i] = 0;
			acc[i] = 0;
			joined[i] = 0;
		end
		formed = 0;
	endfunction

	function automatic void agglomerate();
		int n, lim, b, e, c, w, s, cnt, cur_w, cur_i, best, pick;
		bit found;
		n = live_count();
		lim = cfg.max_macro_size > M_MAX ? M_MAX : int'(cfg.max_macro_size);
		for (int i = 0; i < N_MAX; i++) begin
			labeled[i] = 0;
			mlabel[i] = 0;
			acc[i] = 0;
			joined[i] = 0;
		end
		formed = 0;
		for (int i = 0; i < n; i++) begin
			if (labeled[i])
				continue;
			cnt = 0;
			cur_w = 0;
			cur_i = i;
			best = 0;
			joined[i] = 1;
			members[cnt++] = i;
			row_range(i, b, e);
			for (int k = b; k < e; k++) begin
				c = ent_col[k];
				w = ent_wt[k];
				if (can_join(c, n)) begin
					acc[c] = w;
					if (w > cur_w) begin
						cur_w = w;
						cur_i = c;
					end
				end
			end
			while (cur_w >= int'(cfg.grow_threshold) && cur_w > best && cnt < lim) begin
				best = cur_w;
				members[cnt++] = cur_i;
				joined[cur_i] = 1;
				row_range(cur_i, b, e);
				for (int k = b; k < e; k++) begin
					c = ent_col[k];
					w = ent_wt[k];
					if (can_join(c, n)) begin
						s = acc[c] + w;
						if (s > SAT)
							s = SAT;
						acc[c] = s;
						if (s > cur_w) begin
							cur_w = s;
							cur_i = c;
						end
					end
				end
			end
			for (int k = 0; k < cnt; k++) begin
				joined[members[k]] = 0;
				if (cnt > 1) begin
					labeled[members[k]] = 1;
					mlabel[members[k]] = formed;
				end
			end
			if (cnt > 1)
				formed++;
			for (int k = 0; k < n; k++)
				acc[k] = 0;
		end
		for (int i = 0; i < n; i++) begin
			if (labeled[i])
				continue;
			best = cfg.attach_threshold;
			pick = 0;
			found = 0;
			row_range(i, b, e);
			for (int k = b; k < e; k++) begin
				c = ent_col[k];
				w = ent_wt[k];
				if (c < n && labeled[c] && w > best) begin
					best = w;
					pick = mlabel[c];
					found = 1;
				end
			end
			if (found) begin
				labeled[i] = 1;
				mlabel[i] = pick;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (!labeled[i]) begin
				labeled[i] = 1;
				mlabel[i] = formed++;
			end
		end
	endfunction

	function automatic status_t load_entry(input int r, input logic [31:0] col,
		input logic [15:0] w);
		int n;
		logic [31:0] loc;
		n = live_count();
		loc = col - cfg.element_base;
		if (r >= n)
			return STS_RANGE;
		if (r < top_row)
			return STS_ORDER;
		if (loc >= n)
			return STS_OK;
		if (ent_total >= E_MAX)
			return STS_FULL;
		for (int k = top_row + 1; k <= r; k++)
			row_base[k] = ent_total;
		top_row = r;
		ent_col[ent_total] = int'(loc);
		ent_wt[ent_total] = int'(w);
		ent_total++;
		return STS_OK;
	endfunction

	function automatic beat_t predict(input action_t a);
		beat_t p;
		p.st = STS_OK;
		p.lbl = '0;
		case (a)
			ACT_LOAD: p.st = load_entry(int'(row), column, weight);
			ACT_RUN: agglomerate();
			ACT_READ: begin
				if (read_element < live_count() && labeled[read_element])
					p.lbl = mlabel[read_element][9:0];
				else
					p.st = STS_RANGE;
			end
			default: clear_graph();
		endcase
		p.cnt = formed[10:0];
		return p;
	endfunction

	function automatic void write_reg(input logic [2:0] idx, input logic [31:0] v);
		case (reg_idx_t'(idx))
			REG_ELEMENT_COUNT: cfg.element_count = v[10:0];
			REG_ELEMENT_BASE: cfg.element_base = v;
			REG_GROW_THRESHOLD: cfg.grow_threshold = v[15:0];
			REG_ATTACH_THRESHOLD: cfg.attach_threshold = v[15:0];
			REG_MAX_MACRO_SIZE: cfg.max_macro_size = v[7:0];
			default: ;
		endcase
	endfunction

	function automatic void report(input string what, input int want, input int got);
		errors++;
		if (errors <= 10)
			$display("%t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			model_reset();
			owed.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				write_reg(paddr[4:2], pwdata);
			if (done) begin
				if (owed.size() == 0) begin
					report("unexpected result beat", 0, 1);
				end else begin
					want = owed.pop_front();
					if (status !== want.st)
						report("status", want.st, status);
					if (label !== want.lbl)
						report("label", want.lbl, label);
					if (macro_count !== want.cnt)
						report("macro_count", want.cnt, macro_count);
				end
			end
			if (start && !busy)
				owed.push_back(predict(action_t'(action)));
		end
		pending = owed.size();
	end

endmodule

FILE: dv/greedy_element_agglomeration_test.sv
// Testbench top for the greedy element agglomeration engine: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module greedy_element_agglomeration_test;
	import gea_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic [1:0] action = '0;
	logic [9:0] row = '0;
	logic [31:0] column = '0;
	logic [15:0] weight = '0;
	logic [9:0] read_element = '0;
	logic done;
	logic [1:0] status;
	logic [9:0] label;
	logic [10:0] macro_count;

	int errors;
	int pending;
	int cycles = 0;
	int items = 0;
	bit calm = 0;

	logic [31:0] base;
	logic [15:0] grow;
	int n;

	always #2 clk = ~clk;

	greedy_element_agglomeration u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.action(action), .row(row), .column(column), .weight(weight),
		.read_element(read_element),
		.done(done), .status(status), .label(label), .macro_count(macro_count)
	);

	gea_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.start(start), .busy(busy),
		.action(action), .row(row), .column(column), .weight(weight),
		.read_element(read_element),
		.done(done), .status(status), .label(label), .macro_count(macro_count),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic issue(input action_t a, input int r, input logic [31:0] col,
		input logic [15:0] w, input int re);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 17) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		action <= a;
		row <= r[9:0];
		column <= col;
		weight <= w;
		read_element <= re[9:0];
		start <= 1;
		do @(posedge clk); while (busy);
		items++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic configure(input int cnt, input logic [31:0] b, input logic [15:0] g,
		input logic [15:0] att, input logic [7:0] mx);
		drain();
		set_reg(REG_ELEMENT_COUNT, cnt);
		set_reg(REG_ELEMENT_BASE, b);
		set_reg(REG_GROW_THRESHOLD, g);
		set_reg(REG_ATTACH_THRESHOLD, att);
		set_reg(REG_MAX_MACRO_SIZE, mx);
		n = cnt;
		base = b;
		grow = g;
	endtask

	task automatic load(input int r, input int loc, input logic [15:0] w);
		issue(ACT_LOAD, r, base + loc, w, 0);
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 16'($urandom_range(0, 12));
			5, 6, 7: return 16'($urandom_range(0, 40)) + (grow > 20 ? grow - 20 : 16'd0);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic graph_round();
		int loc;
		issue(ACT_CLEAR, 0, 0, 0, 0);
		for (int r = 0; r < n; r++) begin
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(99) < 8) begin
					issue(action_t'($urandom_range(0, 2)), $urandom_range(0, 1023), $urandom,
						16'($urandom), $urandom_range(0, 1023));
				end else begin
					case ($urandom_range(19))
						0: loc = $urandom;
						1: loc = n + $urandom_range(0, 3);
						default: loc = $urandom_range(0, n - 1);
					endcase
					load(r, loc, pick_weight());
				end
			end
		end
		issue(ACT_RUN, 0, 0, 0, 0);
		for (int e = 0; e < n; e++)
			issue(ACT_READ, 0, 0, 0, e);
		repeat (3)
			issue(ACT_READ, 0, 0, 0, $urandom_range(0, 1023));
	endtask

	function automatic logic [15:0] pick_threshold();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 20));
		endcase
	endfunction

	initial begin
		int phase;
		logic [31:0] b;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		n = 1;
		base = 0;
		grow = 4;

		issue(ACT_READ, 0, 0, 0, 0);
		load(0, 0, 5);
		load(5, 0, 5);
		issue(ACT_LOAD, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);
		issue(ACT_RUN, 0, 0, 0, 0);
		issue(ACT_READ, 0, 0, 0, 0);
		issue(ACT_READ, 0, 0, 0, 1023);
		issue(ACT_CLEAR, 0, 0, 0, 0);

		configure(8, 32'hFFFF_FFFE, 4, 3, 2);
		load(0, 1, 16'hFFFF);
		load(0, 0, 7);
		load(0, 1, 3);
		load(2, 3, 10);
		load(1, 2, 9);
		load(3, 2, 4);
		load(4, 5, 2);
		load(5, 4, 3);
		load(6, 7, 0);
		load(7, 6, 9);
		load(8, 0, 9);
		issue(ACT_RUN, 0, 0, 0, 0);
		for (int e = 0; e < 9; e++)
			issue(ACT_READ, 0, 0, 0, e);

		configure(8, 32'hFFFF_FFFE, 0, 16'hFFFF, 128);
		issue(ACT_RUN, 0, 0, 0, 0);
		issue(ACT_READ, 0, 0, 0, 3);

		phase = 0;
		while (items < 800) begin
			calm = items >= 300 && items < 500;
			case ($urandom_range(2))
				0: b = 0;
				1: b = $urandom;
				default: b = 32'hFFFF_FFFF - $urandom_range(0, 8);
			endcase
			configure(phase % 7 == 0 ? $urandom_range(25, 64) : $urandom_range(1, 16), b,
				pick_threshold(), pick_threshold(),
				phase % 5 == 0 ? 8'd128 : phase % 5 == 1 ? 8'd2 : 8'($urandom_range(2, 10)));
			graph_round();
			phase++;
		end

		calm = 0;
		configure(1024, 0, 16'hFFFF, 16'hFFFF, 128);
		issue(ACT_CLEAR, 0, 0, 0, 0);
		for (int k = 0; k < 150; k++)
			load(k / 17, $urandom_range(0, 1023), 16'($urandom));
		issue(ACT_RUN, 0, 0, 0, 0);
		issue(ACT_READ, 0, 0, 0, 1023);
		issue(ACT_READ, 0, 0, 0, $urandom_range(0, 1023));
		issue(ACT_CLEAR, 0, 0, 0, 0);

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/gea_pkg.sv
hw/rtl/gea_ram.sv
hw/rtl/gea_cfg.sv
hw/rtl/gea_core.sv
hw/rtl/greedy_element_agglomeration.sv
dv/gea_checker.sv
dv/greedy_element_agglomeration_test.sv
